>>> design/line_editor_with_history_defines.svh
// Assertion macros shared by the line editor RTL.
`ifndef LINE_EDITOR_WITH_HISTORY_DEFINES_SVH
`define LINE_EDITOR_WITH_HISTORY_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LEW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define LEW_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> design/lew_pkg.sv
// Types, constants and codes shared by the line editor modules.
package lew_pkg;

  localparam int LINE_MAX = 32;
  localparam int HIST_MAX = 64;
  localparam int LINE_AW  = $clog2(LINE_MAX);
  localparam int HIST_AW  = $clog2(HIST_MAX);

  localparam logic [7:0] BYTE_BS       = 8'h08;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;
  localparam logic [7:0] BYTE_NL       = 8'h0A;
  localparam logic [7:0] BYTE_PRINT_LO = 8'h20;

  localparam logic [1:0] CFG_LINE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_HIST_BYTES = 2'd1;

  typedef enum logic [2:0] {
    KIND_BYTE  = 3'd0,
    KIND_LEFT  = 3'd1,
    KIND_RIGHT = 3'd2,
    KIND_HOME  = 3'd3,
    KIND_END   = 3'd4,
    KIND_UP    = 3'd5,
    KIND_DOWN  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ACT_MOVE_LEFT  = 3'd0,
    ACT_MOVE_RIGHT = 3'd1,
    ACT_DELETE     = 3'd2,
    ACT_OPEN       = 3'd3,
    ACT_WRITE      = 3'd4,
    ACT_SUBMIT     = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    OP_BKSP, OP_SUBMIT, OP_INSERT, OP_LEFT, OP_RIGHT,
    OP_HOME, OP_END, OP_UP, OP_DOWN
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    action_e    action;
    logic [5:0] count;
    logic [7:0] ch;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [5:0] line_limit;
    logic [6:0] history_bytes;
  } cfg_t;

endpackage

>>> design/line_editor_with_history.sv
// Top level of the terminal line editor with history recall.
//
//  channel   direction  handshake                 payload
//  key       in         push / full               kind_i, key_byte_i
//  action    out        empty / pop               action_o, count_o, out_char_o, last_o
//  config    in         cfg_valid_i / cfg_ready_o cfg_addr_i, cfg_data_i
//
// Cursor moves pass through the sequencer's idle and finish states; insert and
// backspace shift the line buffer character by character. Submit sends each
// character, then walks the history entries and moves the bytes in the history
// memory, whose single registered read port sets the pace.
// Recall walks the older entries, then loads each character.
// Reset is asynchronous and clears the line, the history count and the
// browse index; the stores need no clearing pass. A full action queue
// stalls the sequencer, and keys keep queuing in front until that fills.
module line_editor_with_history (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] kind_i,
  input  logic [7:0] key_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] action_o,
  output logic [5:0] count_o,
  output logic [7:0] out_char_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_addr_i,
  input  logic [6:0] cfg_data_i
);
  import lew_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid, cmd_take, res_wr, res_full;
  cmd_t cmd;
  res_t res_in, res_out;

  // the user must write configuration only while idle; not enforced, so accept it at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_limit    <= 6'd32;
      cfg_q.history_bytes <= 7'd64;
    end else if (cfg_valid_i) begin
      // writes to unknown indexes are dropped
      case (cfg_addr_i)
        CFG_LINE_LIMIT: cfg_q.line_limit    <= cfg_data_i[5:0];
        CFG_HIST_BYTES: cfg_q.history_bytes <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // classify keys and hold them until the sequencer is free
  lew_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .key_byte_i  (key_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // carry out each command on the line and history stores
  lew_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_wr_o    (res_wr),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // hold finished actions until each transfer on the result side
  lew_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_wr),
    .wr_data_i (res_in),
    .wr_full_o (res_full),
    .empty_o   (empty),
    .pop_i     (pop),
    .rd_data_o (res_out)
  );

  assign action_o   = res_out.action;
  assign count_o    = res_out.count;
  assign out_char_o = res_out.ch;
  assign last_o     = res_out.last;

endmodule

>>> design/lew_front.sv
// Key classifier and two-entry command queue in front of the sequencer.
module lew_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [2:0]    kind_i,
  input  logic [7:0]    key_byte_i,
  output logic          cmd_valid_o,
  output lew_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);
  import lew_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       keep;
  cmd_t       cmd_new;
  logic       wr_en, rd_en;

  always_comb begin
    keep        = 1'b1;
    cmd_new.ch  = key_byte_i;
    cmd_new.op  = OP_LEFT;
    case (kind_i)
      KIND_BYTE: begin
        if (key_byte_i inside {BYTE_BS, BYTE_DEL}) begin
          cmd_new.op = OP_BKSP;
        end else if (key_byte_i == BYTE_NL) begin
          cmd_new.op = OP_SUBMIT;
        end else if (key_byte_i >= BYTE_PRINT_LO) begin
          cmd_new.op = OP_INSERT;
        end else begin
          keep = 1'b0;
        end
      end
      KIND_LEFT:  cmd_new.op = OP_LEFT;
      KIND_RIGHT: cmd_new.op = OP_RIGHT;
      KIND_HOME:  cmd_new.op = OP_HOME;
      KIND_END:   cmd_new.op = OP_END;
      KIND_UP:    cmd_new.op = OP_UP;
      KIND_DOWN:  cmd_new.op = OP_DOWN;
      default:    keep = 1'b0;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  // ignored keys are taken and dropped here
  assign wr_en       = push_i && !full_o && keep;
  assign rd_en       = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_q[wr_q] <= cmd_new;
  end

endmodule

>>> design/lew_outq.sv
// Two-entry result queue between the sequencer and the result ports.
module lew_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  lew_pkg::res_t wr_data_i,
  output logic          wr_full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output lew_pkg::res_t rd_data_o
);
  import lew_pkg::*;

  res_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign wr_full_o = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_data_o = slot_q[rd_q];
  assign wr_en     = wr_i && !wr_full_o;
  assign rd_en     = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_q[wr_q] <= wr_data_i;
  end

endmodule

>>> design/lew_back.sv
// Edit sequencer: line buffer, history store and terminal action generation.
`include "line_editor_with_history_defines.svh"
module lew_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lew_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  lew_pkg::cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          res_wr_o,
  output lew_pkg::res_t res_o,
  input  logic          res_full_i
);
  import lew_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FIN, ST_BS_SHIFT, ST_BS_DEL, ST_INS_SHIFT, ST_INS_WR, ST_SUB,
    ST_PUSH, ST_PW_ADDR, ST_PW_DATA, ST_MV_ADDR, ST_MV_DATA, ST_CP, ST_DONE,
    ST_CLR_ML, ST_CLR_DEL, ST_RC_ADDR, ST_RC_DATA, ST_RC_SIZE, ST_RC_CADDR,
    ST_RC_CDATA
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cur_q, cur_d, len_q, len_d, browse_q, browse_d;
  logic [6:0] hcnt_q, hcnt_d;
  logic [5:0] i_q, i_d, entry_q, entry_d, size_q, size_d;
  logic [7:0] ch_q, ch_d;
  logic [8:0] idx_q, idx_d;
  logic [6:0] e_q, e_d, avail_q, avail_d, j_q, j_d;
  logic       rec_q, rec_d;
  res_t       pend_q, pend_d;
  logic       pend_v_q, pend_v_d;

  logic [7:0] line_mem [LINE_MAX];
  logic [7:0] hist_mem [HIST_MAX];

  logic               line_we;
  logic [LINE_AW-1:0] line_wa, line_ra;
  logic [7:0]         line_wd, line_rd;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_wa;
  logic [7:0]         hist_wd;
  logic [8:0]         raddr;
  logic [7:0]         rd_q;
  logic               rd_oob_q;
  logic [7:0]         hd;

  logic       emit_req, hold;
  res_t       emit_res;
  logic [5:0] lim, nb;
  logic [6:0] h;
  logic [9:0] es_sum;

  assign line_rd = line_mem[line_ra];
  assign hd      = rd_oob_q ? 8'd0 : rd_q;
  assign lim     = (cfg_i.line_limit > 6'(LINE_MAX)) ? 6'(LINE_MAX) : cfg_i.line_limit;
  assign h       = (cfg_i.history_bytes > 7'(HIST_MAX)) ? 7'(HIST_MAX)
                                                       : cfg_i.history_bytes;
  assign nb      = (browse_q != 6'd0) ? browse_q - 6'd1 : 6'd0;
  assign es_sum  = {1'b0, idx_q} + 10'd1 + {2'b0, hd};

  // history read address, kept equal across each address/data state pair
  always_comb begin
    case (state_q)
      ST_PW_ADDR, ST_PW_DATA, ST_RC_ADDR, ST_RC_DATA, ST_RC_SIZE: raddr = idx_q;
      ST_MV_ADDR, ST_MV_DATA: raddr = {2'b0, j_q} - 9'd1;
      ST_RC_CADDR, ST_RC_CDATA: raddr = idx_q + 9'd1 + {3'b0, i_q};
      default: raddr = idx_q;
    endcase
  end

  always_comb begin
    state_d = state_q;  cur_d = cur_q;  len_d = len_q;  browse_d = browse_q;
    hcnt_d = hcnt_q;    i_d = i_q;      entry_d = entry_q;  size_d = size_q;
    ch_d = ch_q;        idx_d = idx_q;  e_d = e_q;      avail_d = avail_q;
    j_d = j_q;          rec_d = rec_q;  pend_d = pend_q; pend_v_d = pend_v_q;
    cmd_take_o = 1'b0;
    line_we = 1'b0;  line_wa = i_q[LINE_AW-1:0];  line_wd = line_rd;
    line_ra = i_q[LINE_AW-1:0];
    hist_we = 1'b0;  hist_wa = '0;  hist_wd = hd;
    emit_req = 1'b0;
    emit_res = '{action: ACT_MOVE_LEFT, count: 6'd0, ch: 8'd0, last: 1'b0};
    res_wr_o = 1'b0;
    res_o    = pend_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          state_d    = ST_FIN;
          case (cmd_i.op)
            OP_LEFT: if (cur_q != 6'd0) begin
              cur_d = cur_q - 6'd1;
              emit_req = 1'b1; emit_res.action = ACT_MOVE_LEFT; emit_res.count = 6'd1;
            end
            OP_RIGHT: if (cur_q < len_q) begin
              cur_d = cur_q + 6'd1;
              emit_req = 1'b1; emit_res.action = ACT_MOVE_RIGHT; emit_res.count = 6'd1;
            end
            OP_HOME: begin
              if (cur_q != 6'd0) begin
                emit_req = 1'b1; emit_res.action = ACT_MOVE_LEFT; emit_res.count = cur_q;
              end
              cur_d = 6'd0;
            end
            OP_END: begin
              if (len_q > cur_q) begin
                emit_req = 1'b1; emit_res.action = ACT_MOVE_RIGHT;
                emit_res.count = len_q - cur_q;
              end
              cur_d = len_q;
            end
            OP_BKSP: if (cur_q != 6'd0) begin
              i_d = cur_q; state_d = ST_BS_SHIFT;
            end
            OP_INSERT: if (len_q < lim) begin
              i_d = len_q; ch_d = cmd_i.ch; state_d = ST_INS_SHIFT;
            end
            OP_SUBMIT: if (len_q != 6'd0) begin
              i_d = 6'd0; state_d = ST_SUB;
            end
            OP_UP: if (({1'b0, browse_q} < hcnt_q) && (browse_q < 6'd63)) begin
              entry_d = browse_q; rec_d = 1'b1; browse_d = browse_q + 6'd1;
              state_d = ST_CLR_ML;
            end
            OP_DOWN: begin
              browse_d = nb;
              entry_d  = nb - 6'd1;
              rec_d    = (nb != 6'd0) && ({1'b0, nb - 6'd1} < hcnt_q);
              state_d  = ST_CLR_ML;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (pend_v_q) begin
          if (!res_full_i) begin
            res_wr_o = 1'b1; res_o.last = 1'b1; pend_v_d = 1'b0; state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BS_SHIFT: begin
        if (i_q < len_q) begin
          line_we = 1'b1; line_wa = LINE_AW'(i_q - 6'd1); i_d = i_q + 6'd1;
        end else begin
          cur_d = cur_q - 6'd1; len_d = len_q - 6'd1;
          emit_req = 1'b1; emit_res.action = ACT_MOVE_LEFT; emit_res.count = 6'd1;
          state_d = ST_BS_DEL;
        end
      end
      ST_BS_DEL: begin
        emit_req = 1'b1; emit_res.action = ACT_DELETE; emit_res.count = 6'd1;
        state_d = ST_FIN;
      end
      ST_INS_SHIFT: begin
        line_ra = LINE_AW'(i_q - 6'd1);
        if (i_q > cur_q) begin
          line_we = 1'b1; i_d = i_q - 6'd1;
        end else begin
          line_we = 1'b1; line_wa = cur_q[LINE_AW-1:0]; line_wd = ch_q;
          cur_d = cur_q + 6'd1; len_d = len_q + 6'd1; browse_d = 6'd0;
          emit_req = 1'b1; emit_res.action = ACT_OPEN; emit_res.count = 6'd1;
          state_d = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        emit_req = 1'b1; emit_res.action = ACT_WRITE; emit_res.ch = ch_q;
        state_d = ST_FIN;
      end
      ST_SUB: begin
        emit_req = 1'b1; emit_res.action = ACT_SUBMIT; emit_res.ch = line_rd;
        if (i_q == len_q - 6'd1) state_d = ST_PUSH;
        else i_d = i_q + 6'd1;
      end
      ST_PUSH: begin
        if (h == 7'd0) begin
          state_d = ST_DONE;
        end else begin
          size_d  = ({1'b0, len_q} < h - 7'd1) ? len_q : 6'(h - 7'd1);
          avail_d = h - 7'd1 - (({1'b0, len_q} < h - 7'd1) ? {1'b0, len_q} : h - 7'd1);
          idx_d = 9'd0; e_d = 7'd0; state_d = ST_PW_ADDR;
        end
      end
      ST_PW_ADDR: begin
        if (e_q < hcnt_q) state_d = ST_PW_DATA;
        else begin
          j_d = idx_q[6:0]; state_d = ST_MV_ADDR;
        end
      end
      ST_PW_DATA: begin
        // drop this entry and everything older when it no longer fits
        if (es_sum > {3'b0, avail_q}) begin
          hcnt_d = e_q; j_d = idx_q[6:0]; state_d = ST_MV_ADDR;
        end else begin
          idx_d = es_sum[8:0]; e_d = e_q + 7'd1; state_d = ST_PW_ADDR;
        end
      end
      ST_MV_ADDR: begin
        if (j_q != 7'd0) state_d = ST_MV_DATA;
        else begin
          i_d = 6'd0; state_d = ST_CP;
        end
      end
      ST_MV_DATA: begin
        hist_we = 1'b1; hist_wa = HIST_AW'({1'b0, size_q} + j_q);
        j_d = j_q - 7'd1; state_d = ST_MV_ADDR;
      end
      ST_CP: begin
        if (i_q < size_q) begin
          hist_we = 1'b1; hist_wa = HIST_AW'(i_q + 6'd1); hist_wd = line_rd;
          i_d = i_q + 6'd1;
        end else begin
          hist_we = 1'b1; hist_wa = '0; hist_wd = {2'b0, size_q};
          hcnt_d = hcnt_q + 7'd1; state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cur_d = 6'd0; len_d = 6'd0; browse_d = 6'd0; state_d = ST_FIN;
      end
      ST_CLR_ML: begin
        if (cur_q != 6'd0) begin
          emit_req = 1'b1; emit_res.action = ACT_MOVE_LEFT; emit_res.count = cur_q;
        end
        cur_d = 6'd0; state_d = ST_CLR_DEL;
      end
      ST_CLR_DEL: begin
        if (len_q != 6'd0) begin
          emit_req = 1'b1; emit_res.action = ACT_DELETE; emit_res.count = len_q;
        end
        len_d = 6'd0;
        if (rec_q) begin
          idx_d = 9'd0; e_d = 7'd0; state_d = ST_RC_ADDR;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RC_ADDR: begin
        if (e_q < {1'b0, entry_q}) state_d = ST_RC_DATA;
        else state_d = ST_RC_SIZE;
      end
      ST_RC_DATA: begin
        idx_d = es_sum[8:0]; e_d = e_q + 7'd1; state_d = ST_RC_ADDR;
      end
      ST_RC_SIZE: begin
        size_d = ({2'b0, lim} < hd) ? lim : hd[5:0];
        i_d = 6'd0; state_d = ST_RC_CADDR;
      end
      ST_RC_CADDR: begin
        if (i_q < size_q) state_d = ST_RC_CDATA;
        else begin
          cur_d = size_q; len_d = size_q; state_d = ST_FIN;
        end
      end
      ST_RC_CDATA: begin
        line_we = 1'b1; line_wd = hd;
        emit_req = 1'b1; emit_res.action = ACT_WRITE; emit_res.ch = hd;
        i_d = i_q + 6'd1; state_d = ST_RC_CADDR;
      end
      default: state_d = ST_IDLE;
    endcase

    // a new action moves the held one on; if the queue is full while one is held, hold everything
    hold = emit_req && pend_v_q && res_full_i;
    if (emit_req && !hold) begin
      res_wr_o = pend_v_q;
      res_o    = pend_q;
      pend_d   = emit_res;
      pend_v_d = 1'b1;
    end
    if (hold) begin
      state_d = state_q;  cur_d = cur_q;  len_d = len_q;  browse_d = browse_q;
      hcnt_d = hcnt_q;    i_d = i_q;      entry_d = entry_q;  size_d = size_q;
      ch_d = ch_q;        idx_d = idx_q;  e_d = e_q;      avail_d = avail_q;
      j_d = j_q;          rec_d = rec_q;
      cmd_take_o = 1'b0;  line_we = 1'b0; hist_we = 1'b0; res_wr_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_q    <= 6'd0;
      len_q    <= 6'd0;
      browse_q <= 6'd0;
      hcnt_q   <= 7'd0;
      pend_v_q <= 1'b0;
      rec_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      len_q    <= len_d;
      browse_q <= browse_d;
      hcnt_q   <= hcnt_d;
      pend_v_q <= pend_v_d;
      rec_q    <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    entry_q <= entry_d;
    size_q  <= size_d;
    ch_q    <= ch_d;
    idx_q   <= idx_d;
    e_q     <= e_d;
    avail_q <= avail_d;
    j_q     <= j_d;
    pend_q  <= pend_d;
  end

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_wa] <= line_wd;
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    rd_q     <= hist_mem[raddr[HIST_AW-1:0]];
    rd_oob_q <= (raddr >= 9'(HIST_MAX));
  end

  `LEW_ASSERT(a_cursor_in_line, cur_q <= len_q, "cursor beyond line end")
  `LEW_NEVER(a_idle_pending, (state_q == ST_IDLE) && pend_v_q, "action held while idle")
  `LEW_ASSERT(a_hold_keeps_state, hold |=> (state_q == $past(state_q)), "stall moved state")
  `LEW_ASSERT(a_hist_count, hcnt_q <= 7'(HIST_MAX), "history count too large")

endmodule
